[rtl/button_press_duration_classifier_unit_defines.svh]
// Assertion macros for the button press duration classifier.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bpdc_pkg.sv]
// Shared types and codes of the button press duration classifier.
`default_nettype none

package bpdc_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned PROG_W = 4;

  typedef enum logic [2:0] {
    PH_RELEASE_WAIT = 3'd0,
    PH_PRESS_WAIT   = 3'd1,
    PH_HELD         = 3'd2,
    PH_SHORT        = 3'd3,
    PH_LONG         = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_SHORT_TICKS   = 2'd0;
  localparam logic [1:0] CFG_LONG_TICKS    = 2'd1;
  localparam logic [1:0] CFG_PROGRAM_COUNT = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [PROG_W-1:0] prog_count;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TICK_W-1:0] stamp;
    logic [PROG_W-1:0] prog;
    logic              enabled;
  } ctrl_state_t;

  typedef struct packed {
    logic [PROG_W-1:0] prog;
    logic              clear;
    logic              restart;
    kind_t             kind;
  } result_t;

endpackage

`default_nettype wire

[rtl/bpdc_step.sv]
// One machine step of the classifier: next state and result for one poll.
`default_nettype none

module bpdc_step #(
  parameter int unsigned TICK_WRAP = 65535
) (
  input  bpdc_pkg::cfg_t                    cfg,
  input  bpdc_pkg::ctrl_state_t             state,
  input  logic                              pressed,
  input  logic [bpdc_pkg::TICK_W-1:0]       now,
  output bpdc_pkg::ctrl_state_t             state_next,
  output bpdc_pkg::result_t                 res
);

  localparam logic [bpdc_pkg::TICK_W-1:0] WRAP = bpdc_pkg::TICK_W'(TICK_WRAP);
  localparam logic [bpdc_pkg::PROG_W-1:0] PROG_ONE = bpdc_pkg::PROG_W'(1);

  bpdc_pkg::ctrl_state_t   cur;
  logic [bpdc_pkg::TICK_W-1:0] held;

  always_comb begin
    cur = state;
    if (!state.enabled) begin
      cur.prog    = PROG_ONE;
      cur.enabled = 1'b1;
      cur.phase   = bpdc_pkg::PH_RELEASE_WAIT;
    end
  end

  always_comb begin
    if (cur.stamp <= now) begin
      held = now - cur.stamp;
    end else begin
      held = (WRAP - cur.stamp) + now;
    end
  end

  always_comb begin
    state_next  = cur;
    res.clear   = 1'b0;
    res.restart = 1'b0;
    res.kind    = bpdc_pkg::KIND_NONE;
    case (cur.phase)
      bpdc_pkg::PH_PRESS_WAIT: begin
        if (pressed) begin
          state_next.stamp = now;
          state_next.phase = bpdc_pkg::PH_HELD;
        end
      end
      bpdc_pkg::PH_HELD: begin
        if (!pressed) begin
          if (held >= cfg.long_ticks) begin
            state_next.phase = bpdc_pkg::PH_LONG;
          end else if (held >= cfg.short_ticks) begin
            state_next.phase = bpdc_pkg::PH_SHORT;
          end else begin
            state_next.phase = bpdc_pkg::PH_PRESS_WAIT;
          end
        end else if (held >= cfg.long_ticks) begin
          state_next.phase = bpdc_pkg::PH_LONG;
        end
      end
      bpdc_pkg::PH_SHORT: begin
        if (cur.prog < cfg.prog_count) begin
          state_next.prog = cur.prog + PROG_ONE;
        end else begin
          state_next.prog = PROG_ONE;
        end
        res.clear        = 1'b1;
        res.restart      = 1'b1;
        res.kind         = bpdc_pkg::KIND_SHORT;
        state_next.phase = bpdc_pkg::PH_RELEASE_WAIT;
      end
      bpdc_pkg::PH_LONG: begin
        state_next.prog    = '0;
        state_next.enabled = 1'b0;
        res.clear          = 1'b1;
        res.kind           = bpdc_pkg::KIND_LONG;
        state_next.phase   = bpdc_pkg::PH_RELEASE_WAIT;
      end
      default: begin
        state_next.phase = pressed ? bpdc_pkg::PH_RELEASE_WAIT : bpdc_pkg::PH_PRESS_WAIT;
      end
    endcase
    res.prog = state_next.prog;
  end

endmodule

`default_nettype wire

[rtl/button_press_duration_classifier_unit.sv]
// Top level of the button press duration classifier.
//
// Poll channel: poll_valid/poll_stall carry one beat per poll with the
// button level and the current tick value. Every accepted beat takes one
// step of the press machine and yields exactly one result beat.
// Result channel: res_valid/res_stall carry the selected program, the
// clear and restart pulses and the press kind of that step.
// Results are registered. Throughput is one poll per cycle while
// poll_stall is low; the state update is a single registered step.
// An output register and a one-beat skid register part the channels, so
// a poll is still taken while one result waits; poll_stall rises only
// when both hold a beat, and drops once the receiver takes one.
// The config port (cfg_we, cfg_index, cfg_data) writes the short or long
// limit or the program count, as cfg_index selects; write only while idle.
// Synchronous reset loads the default limits, the release wait phase,
// program 0 and the disabled flag, and empties both result registers.
`default_nettype none

`include "button_press_duration_classifier_unit_defines.svh"

module button_press_duration_classifier_unit #(
  parameter int unsigned TICK_WRAP = 65535
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          poll_valid,
  output logic                          poll_stall,
  input  logic                          button_pressed,
  input  logic [bpdc_pkg::TICK_W-1:0]   tick_now,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [bpdc_pkg::PROG_W-1:0]   program_res,
  output logic                          clear_leds,
  output logic                          restart_program,
  output logic [1:0]                    press_kind,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bpdc_pkg::TICK_W-1:0]   cfg_data
);

  bpdc_pkg::cfg_t        cfg;
  bpdc_pkg::ctrl_state_t state;
  bpdc_pkg::ctrl_state_t state_next;
  bpdc_pkg::result_t     step_res;
  bpdc_pkg::result_t     res;
  bpdc_pkg::result_t     skid;
  logic                  skid_valid;
  logic                  accept;
  logic                  take;

  assign poll_stall = skid_valid;
  assign accept     = poll_valid && !skid_valid;
  assign take       = res_valid && !res_stall;

  bpdc_step #(
    .TICK_WRAP(TICK_WRAP)
  ) u_step (
    .cfg       (cfg),
    .state     (state),
    .pressed   (button_pressed),
    .now       (tick_now),
    .state_next(state_next),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ticks <= 16'd50;
      cfg.long_ticks  <= 16'd2000;
      cfg.prog_count  <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        bpdc_pkg::CFG_SHORT_TICKS:   cfg.short_ticks <= cfg_data;
        bpdc_pkg::CFG_LONG_TICKS:    cfg.long_ticks  <= cfg_data;
        bpdc_pkg::CFG_PROGRAM_COUNT: cfg.prog_count  <= cfg_data[bpdc_pkg::PROG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase   <= bpdc_pkg::PH_RELEASE_WAIT;
      state.stamp   <= '0;
      state.prog    <= '0;
      state.enabled <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end else if (accept) begin
        res <= step_res;
      end else begin
        res_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!res_valid) begin
        res       <= step_res;
        res_valid <= 1'b1;
      end else begin
        skid       <= step_res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign program_res     = res.prog;
  assign clear_leds      = res.clear;
  assign restart_program = res.restart;
  assign press_kind      = res.kind;

  `BPDC_ASSERT_NOW(a_skid_behind_out, skid_valid, res_valid, "skid holds a beat while output is empty")
  `BPDC_ASSERT_NOW(a_long_turns_off, res_valid && res.kind == bpdc_pkg::KIND_LONG,
    res.prog == '0 && res.clear && !res.restart, "long press result malformed")
  `BPDC_ASSERT_NOW(a_restart_clears, res_valid && res.restart,
    res.clear && res.kind == bpdc_pkg::KIND_SHORT, "restart without short press clear")
  `BPDC_ASSERT_NEXT(a_long_disables, accept && state.enabled && state.phase == bpdc_pkg::PH_LONG,
    !state.enabled && state.phase == bpdc_pkg::PH_RELEASE_WAIT, "long press did not disable")

endmodule

`default_nettype wire

[tb/sv/button_press_duration_classifier_unit_tb.sv]
// Self-checking testbench for the button press duration classifier unit.
`default_nettype none

module button_press_duration_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpdc_pkg::*;

  localparam int unsigned TICK_WRAP   = 65535;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic              pressed;
    logic [TICK_W-1:0] tick;
    int unsigned       gap;
  } poll_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              poll_valid = 1'b0;
  logic              poll_stall;
  logic              button_pressed = 1'b0;
  logic [TICK_W-1:0] tick_now = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [PROG_W-1:0] program_res;
  logic              clear_leds;
  logic              restart_program;
  logic [1:0]        press_kind;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_SHORT_TICKS;
  logic [TICK_W-1:0] cfg_data = '0;

  button_press_duration_classifier_unit #(
    .TICK_WRAP(TICK_WRAP)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .poll_valid     (poll_valid),
    .poll_stall     (poll_stall),
    .button_pressed (button_pressed),
    .tick_now       (tick_now),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .program_res    (program_res),
    .clear_leds     (clear_leds),
    .restart_program(restart_program),
    .press_kind     (press_kind),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  poll_beat_t        pending_polls[$];
  result_t           expected_results[$];
  int unsigned       polls_queued = 0;
  int unsigned       polls_taken = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  bit                calm = 1'b0;
  logic              poll_took = 1'b0;
  logic              res_took = 1'b0;
  logic [TICK_W-1:0] tick_cursor;

  // press machine mirror
  phase_t            ph = PH_RELEASE_WAIT;
  logic [TICK_W-1:0] stamp = '0;
  logic [PROG_W-1:0] prog_sel = '0;
  logic              prog_on = 1'b0;
  logic [TICK_W-1:0] lim_short = 16'd50;
  logic [TICK_W-1:0] lim_long = 16'd2000;
  logic [PROG_W-1:0] prog_total = 4'd2;

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic result_t classify_poll(input logic pressed, input logic [TICK_W-1:0] now);
    result_t           r;
    logic [TICK_W-1:0] held;
    r.prog    = '0;
    r.clear   = 1'b0;
    r.restart = 1'b0;
    r.kind    = KIND_NONE;
    if (!prog_on) begin
      prog_sel = 4'd1;
      prog_on  = 1'b1;
      ph       = PH_RELEASE_WAIT;
    end
    case (ph)
      PH_PRESS_WAIT: begin
        if (pressed) begin
          stamp = now;
          ph    = PH_HELD;
        end
      end
      PH_HELD: begin
        if (stamp <= now) held = now - stamp;
        else held = TICK_W'(TICK_WRAP - int'(stamp) + int'(now));
        if (!pressed) begin
          if (held >= lim_long) ph = PH_LONG;
          else if (held >= lim_short) ph = PH_SHORT;
          else ph = PH_PRESS_WAIT;
        end else if (held >= lim_long) begin
          ph = PH_LONG;
        end
      end
      PH_SHORT: begin
        if (prog_sel < prog_total) prog_sel = prog_sel + 4'd1;
        else prog_sel = 4'd1;
        r.clear   = 1'b1;
        r.restart = 1'b1;
        r.kind    = KIND_SHORT;
        ph        = PH_RELEASE_WAIT;
      end
      PH_LONG: begin
        prog_sel = '0;
        prog_on  = 1'b0;
        r.clear  = 1'b1;
        r.kind   = KIND_LONG;
        ph       = PH_RELEASE_WAIT;
      end
      default: ph = pressed ? PH_RELEASE_WAIT : PH_PRESS_WAIT;
    endcase
    r.prog = prog_sel;
    return r;
  endfunction

  // check result beats, then predict for the accepted poll beat
  always @(posedge clk) begin
    result_t want;
    cycle_count <= cycle_count + 1;
    poll_took   <= !rst && poll_valid && !poll_stall;
    res_took    <= !rst && res_valid && !res_stall;
    if (rst) begin
      ph         = PH_RELEASE_WAIT;
      stamp      = '0;
      prog_sel   = '0;
      prog_on    = 1'b0;
      lim_short  = 16'd50;
      lim_long   = 16'd2000;
      prog_total = 4'd2;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: prog %0d clear %0b restart %0b kind %0d",
                     program_res, clear_leds, restart_program, press_kind);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (program_res !== want.prog || clear_leds !== want.clear ||
              restart_program !== want.restart || press_kind !== want.kind) begin
            if (mismatch_count < 10)
              $display({"result mismatch: expected prog %0d clear %0b restart %0b kind %0d,",
                        " got prog %0d clear %0b restart %0b kind %0d"},
                       want.prog, want.clear, want.restart, want.kind,
                       program_res, clear_leds, restart_program, press_kind);
            mismatch_count++;
          end
        end
      end
      if (poll_valid && !poll_stall) begin
        expected_results.push_back(classify_poll(button_pressed, tick_now));
        polls_taken++;
      end
    end
  end

  poll_beat_t  cur_poll;
  bit          staged = 1'b0;
  bit          poll_next;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
      staged = 1'b0;
    end else if (!poll_valid || poll_took) begin
      poll_next = 1'b0;
      if (!staged && pending_polls.size() != 0) begin
        cur_poll  = pending_polls.pop_front();
        hold_left = cur_poll.gap;
        staged    = 1'b1;
      end
      if (staged) begin
        if (hold_left != 0) begin
          hold_left--;
        end else begin
          poll_next = 1'b1;
          button_pressed <= cur_poll.pressed;
          tick_now       <= cur_poll.tick;
          staged = 1'b0;
        end
      end
      poll_valid <= poll_next;
    end
  end

  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_took) stall_left = pick_gap();
      if (stall_left != 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic emit(input logic pressed, input logic [TICK_W-1:0] tick);
    pending_polls.push_back('{pressed, tick, pick_gap()});
    polls_queued++;
  endtask

  // release, press, some held polls, release, then one poll to act on it
  task automatic queue_press(input int unsigned dur);
    int unsigned       n;
    logic [TICK_W-1:0] start;
    emit(1'b0, tick_cursor);
    tick_cursor = tick_cursor + TICK_W'($urandom_range(0, 3));
    start = tick_cursor;
    emit(1'b1, start);
    n = $urandom_range(0, 4);
    for (int unsigned i = 1; i <= n; i++)
      emit(1'b1, start + TICK_W'(dur * i / (n + 1)));
    tick_cursor = start + TICK_W'(dur);
    emit(1'b0, tick_cursor);
    tick_cursor = tick_cursor + 16'd1;
    emit(1'($urandom_range(0, 1)), tick_cursor);
  endtask

  function automatic int unsigned pick_dur();
    int v;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, lim_short);
      1: return $urandom_range(lim_short, lim_long);
      2: return int'(lim_long) + $urandom_range(0, 50);
      3: begin
        v = ($urandom_range(0, 1) ? int'(lim_short) : int'(lim_long)) +
            int'($urandom_range(0, 2)) - 1;
        return (v < 0) ? 0 : v;
      end
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (polls_taken != polls_queued || expected_results.size() != 0);
  endtask

  // call at a falling edge once the block is idle
  task automatic apply_config(input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] l,
                              input logic [PROG_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SHORT_TICKS;
    cfg_data  <= s;
    lim_short = s;
    @(negedge clk);
    cfg_index <= CFG_LONG_TICKS;
    cfg_data  <= l;
    lim_long = l;
    @(negedge clk);
    cfg_index <= CFG_PROGRAM_COUNT;
    cfg_data  <= TICK_W'(c);
    prog_total = c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] l,
                            input logic [PROG_W-1:0] c, input int unsigned count);
    int unsigned target;
    wait_drained();
    apply_config(s, l, c);
    calm = ($urandom_range(0, 3) == 0);
    @(posedge clk);
    target = polls_queued + count;
    while (polls_queued < target) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_press(pick_dur());
      end else begin
        repeat ($urandom_range(1, 4))
          emit(1'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    tick_cursor = TICK_W'($urandom_range(0, 65535));
    while (rst) @(negedge clk);

    // default limits: wrapped stamp, short, long on release, long while held
    @(posedge clk);
    emit(1'b1, 16'd0);
    emit(1'b0, 16'd0);
    emit(1'b1, 16'd65530);
    emit(1'b1, 16'd65535);
    emit(1'b0, 16'd40);
    emit(1'b1, 16'd100);
    emit(1'b0, 16'd150);
    emit(1'b1, 16'd150);
    emit(1'b0, 16'd151);
    emit(1'b1, 16'd200);
    emit(1'b0, 16'd2200);
    emit(1'b0, 16'd2201);
    emit(1'b0, 16'd2202);
    emit(1'b1, 16'd3000);
    emit(1'b1, 16'd4999);
    emit(1'b1, 16'd5000);
    emit(1'b1, 16'd5001);

    // zero limits: the first held poll is already long
    wait_drained();
    apply_config(16'd0, 16'd0, 4'd1);
    @(posedge clk);
    emit(1'b0, 16'd7);
    emit(1'b1, 16'd8);
    emit(1'b1, 16'd8);
    emit(1'b0, 16'd9);

    // widest limits
    wait_drained();
    apply_config(16'd65535, 16'd65535, 4'd15);
    @(posedge clk);
    emit(1'b0, 16'd1);
    emit(1'b1, 16'd0);
    emit(1'b1, 16'd65535);
    emit(1'b0, 16'd0);

    // program count of zero
    wait_drained();
    apply_config(16'd5, 16'd10, 4'd0);
    @(posedge clk);
    emit(1'b0, 16'd0);
    emit(1'b1, 16'd100);
    emit(1'b0, 16'd107);
    emit(1'b0, 16'd108);

    run_random(16'd10, 16'd40, 4'd3, 100);
    run_random(16'd0, 16'd30, 4'd15, 100);
    run_random(16'd5, 16'd6, 4'd1, 100);
    repeat (4)
      run_random(TICK_W'($urandom_range(0, 200)), TICK_W'($urandom_range(0, 400)),
                 PROG_W'($urandom_range(1, 15)), 100);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
